/* rtl/dfs_discover_finish_timestamps_defines.svh */
// Assertion macros shared by the search block's RTL files.
// No dependencies; included by the files that assert.
`ifndef DFS_DISCOVER_FINISH_TIMESTAMPS_DEFINES_SVH
`define DFS_DISCOVER_FINISH_TIMESTAMPS_DEFINES_SVH

// Plain property, checked on every rising clock edge out of reset.
`define DFS_ASSERT(LBL, CLK, RSTN, PROP, MSG) \
	LBL: assert property (@(posedge CLK) disable iff (!RSTN) (PROP)) else $error(MSG);

// Antecedent this cycle implies consequent on the next edge.
`define DFS_ASSERT_NEXT(LBL, CLK, RSTN, ANTE, CONS, MSG) \
	LBL: assert property (@(posedge CLK) disable iff (!RSTN) (ANTE) |=> (CONS)) \
		else $error(MSG);

`endif

/* rtl/dfs_pkg.sv */
// Shared types and constants for the depth-first search timestamp block.
// No dependencies; used by the interfaces, controller, datapath and top level.
package dfs_pkg;

	localparam int DEF_MAX_VERTICES = 64;
	localparam int CMD_W  = 2;
	localparam int VTX_W  = 7;
	localparam int TIME_W = 8;

	typedef enum logic [CMD_W-1:0] {
		CMD_ADD   = 2'd0,
		CMD_RUN   = 2'd1,
		CMD_CLEAR = 2'd2
	} cmd_code_t;

	// controller -> datapath
	typedef struct packed {
		logic clear_all;
		logic latch_edge;
		logic edge_rd;
		logic edge_wr;
		logic run_init;
		logic root_start;
		logic row_rd;
		logic push;
		logic pop;
		logic top_load;
		logic emit_rd;
		logic emit_ld;
	} dfs_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic edge_ok;
		logic root_nz;
		logic cand_nz;
		logic depth_one;
		logic emit_last;
		logic out_free;
	} dfs_sts_t;

endpackage

/* rtl/dfs_req_if.sv */
// Command channel: valid/ready plus one command beat.
// Depends on dfs_pkg for field widths.
interface dfs_req_if;
	import dfs_pkg::*;

	logic               valid;
	logic               ready;
	logic [CMD_W-1:0]   cmd;
	logic [VTX_W-1:0]   from_vertex;
	logic [VTX_W-1:0]   to_vertex;

	modport source (output valid, cmd, from_vertex, to_vertex, input ready);
	modport sink   (input valid, cmd, from_vertex, to_vertex, output ready);
endinterface

/* rtl/dfs_rsp_if.sv */
// Result channel: valid/ready plus one timestamp beat per vertex.
// Depends on dfs_pkg for field widths.
interface dfs_rsp_if;
	import dfs_pkg::*;

	logic               valid;
	logic               ready;
	logic [VTX_W-1:0]   vertex;
	logic [TIME_W-1:0]  discover_time;
	logic [TIME_W-1:0]  finish_time;
	logic               last;

	modport source (output valid, vertex, discover_time, finish_time, last, input ready);
	modport sink   (input valid, vertex, discover_time, finish_time, last, output ready);
endinterface

/* rtl/dfs_ctrl.sv */
// Sequencer for edge loads, the search walk and result emission.
// Depends on dfs_pkg (command/status structs) and the assertion macro header.
`include "dfs_discover_finish_timestamps_defines.svh"

module dfs_ctrl (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      req_valid,
	input  logic [dfs_pkg::CMD_W-1:0] req_cmd,
	output logic                      req_ready,
	input  dfs_pkg::dfs_sts_t         sts,
	output dfs_pkg::dfs_cmd_t         cmd
);
	import dfs_pkg::*;

	typedef enum logic [9:0] {
		ST_IDLE     = 10'b00_0000_0001,
		ST_EDGE_RD  = 10'b00_0000_0010,
		ST_EDGE_WR  = 10'b00_0000_0100,
		ST_RUN_INIT = 10'b00_0000_1000,
		ST_ROOT     = 10'b00_0001_0000,
		ST_ROW_RD   = 10'b00_0010_0000,
		ST_SCAN     = 10'b00_0100_0000,
		ST_POP_TOP  = 10'b00_1000_0000,
		ST_EMIT_RD  = 10'b01_0000_0000,
		ST_EMIT_LD  = 10'b10_0000_0000
	} state_t;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		cmd       = '0;
		state_d   = state_q;
		req_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) begin
					unique case (req_cmd)
						CMD_ADD: begin
							if (sts.edge_ok) begin
								cmd.latch_edge = 1'b1;
								state_d        = ST_EDGE_RD;
							end
						end
						CMD_RUN:   state_d       = ST_RUN_INIT;
						CMD_CLEAR: cmd.clear_all = 1'b1;
						default: ;
					endcase
				end
			end
			ST_EDGE_RD: begin
				cmd.edge_rd = 1'b1;
				state_d     = ST_EDGE_WR;
			end
			ST_EDGE_WR: begin
				cmd.edge_wr = 1'b1;
				state_d     = ST_IDLE;
			end
			ST_RUN_INIT: begin
				cmd.run_init = 1'b1;
				state_d      = ST_ROOT;
			end
			ST_ROOT: begin
				if (sts.root_nz) begin
					cmd.root_start = 1'b1;
					state_d        = ST_ROW_RD;
				end else begin
					state_d = ST_EMIT_RD;
				end
			end
			ST_ROW_RD: begin
				cmd.row_rd = 1'b1;
				state_d    = ST_SCAN;
			end
			ST_SCAN: begin
				if (sts.cand_nz) begin
					cmd.push = 1'b1;
					state_d  = ST_ROW_RD;
				end else begin
					// finishing the tree root empties the stack
					cmd.pop = 1'b1;
					state_d = sts.depth_one ? ST_ROOT : ST_POP_TOP;
				end
			end
			ST_POP_TOP: begin
				cmd.top_load = 1'b1;
				state_d      = ST_ROW_RD;
			end
			ST_EMIT_RD: begin
				cmd.emit_rd = 1'b1;
				state_d     = ST_EMIT_LD;
			end
			ST_EMIT_LD: begin
				if (sts.out_free) begin
					cmd.emit_ld = 1'b1;
					state_d     = sts.emit_last ? ST_IDLE : ST_EMIT_RD;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	`DFS_ASSERT_NEXT(a_emit_holds, clk, arst_n, state_q == ST_EMIT_LD && !sts.out_free, state_q == ST_EMIT_LD, "emit state left while output slot busy")

endmodule

/* rtl/dfs_dp.sv */
// Datapath: adjacency row memory with row valid bits, visited marks, path stack,
// time stamps and the output register. Depends on dfs_pkg and the macro header.
`include "dfs_discover_finish_timestamps_defines.svh"

module dfs_dp #(
	parameter int MAX_VERTICES = dfs_pkg::DEF_MAX_VERTICES
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  logic [dfs_pkg::VTX_W-1:0]  cfg_wdata,
	input  logic [dfs_pkg::VTX_W-1:0]  req_from,
	input  logic [dfs_pkg::VTX_W-1:0]  req_to,
	input  dfs_pkg::dfs_cmd_t          cmd,
	output dfs_pkg::dfs_sts_t          sts,
	input  logic                       rsp_ready,
	output logic                       rsp_valid,
	output logic [dfs_pkg::VTX_W-1:0]  rsp_vertex,
	output logic [dfs_pkg::TIME_W-1:0] rsp_discover_time,
	output logic [dfs_pkg::TIME_W-1:0] rsp_finish_time,
	output logic                       rsp_last
);
	import dfs_pkg::*;

	localparam int VW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
	localparam int NW = $clog2(MAX_VERTICES + 1);
	localparam logic [VTX_W-1:0] MAXV = VTX_W'(MAX_VERTICES);
	localparam logic [MAX_VERTICES-1:0] ONE_BIT = {{(MAX_VERTICES-1){1'b0}}, 1'b1};

	// configuration
	logic [VTX_W-1:0] vc_q;

	// edge load
	logic [VTX_W-1:0] from_q, to_q;
	logic [VW-1:0]    from_idx, to_idx;

	// adjacency memory
	logic [MAX_VERTICES-1:0] adj_mem [MAX_VERTICES];
	logic [MAX_VERTICES-1:0] row_ok_q;
	logic [MAX_VERTICES-1:0] row_q;
	logic                    row_ok_rd_q;
	logic [MAX_VERTICES-1:0] row_eff;
	logic [VW-1:0]           rd_addr;

	// search state
	logic [NW-1:0]           n_q;
	logic [MAX_VERTICES-1:0] visited_q;
	logic [MAX_VERTICES-1:0] live;
	logic [MAX_VERTICES-1:0] cand, unvis, ffs_in;
	logic [VW-1:0]           ffs_idx;
	logic [NW-1:0]           depth_q;
	logic [TIME_W-1:0]       time_q;
	logic [VW-1:0]           top_q;
	logic [VW-1:0]           v_q;
	logic                    mark;
	logic [VTX_W-1:0]        n_clamp;

	// stamp and stack memories
	logic [TIME_W-1:0] disc_mem [MAX_VERTICES];
	logic [TIME_W-1:0] fin_mem  [MAX_VERTICES];
	logic [VW-1:0]     stk_mem  [MAX_VERTICES];
	logic [TIME_W-1:0] disc_rd_q, fin_rd_q;
	logic [VW-1:0]     stk_rd_q;

	// output register
	logic                rsp_valid_q;
	logic [VTX_W-1:0]    rsp_vertex_q;
	logic [TIME_W-1:0]   rsp_disc_q, rsp_fin_q;
	logic                rsp_last_q;

	assign from_idx = VW'(from_q - VTX_W'(1));
	assign to_idx   = VW'(to_q - VTX_W'(1));
	assign rd_addr  = cmd.edge_rd ? from_idx : top_q;
	assign row_eff  = row_ok_rd_q ? row_q : '0;
	assign mark     = cmd.root_start | cmd.push;

	// 0 acts as one vertex, anything above the array size as the full size
	assign n_clamp = (vc_q == '0) ? VTX_W'(1) : ((vc_q > MAXV) ? MAXV : vc_q);

	always_comb begin
		for (int i = 0; i < MAX_VERTICES; i++) begin
			live[i] = (NW'(i) < n_q);
		end
	end

	assign unvis  = ~visited_q & live;
	assign cand   = row_eff & unvis;
	assign ffs_in = cmd.root_start ? unvis : cand;

	// lowest set bit
	always_comb begin
		ffs_idx = '0;
		for (int i = MAX_VERTICES - 1; i >= 0; i--) begin
			if (ffs_in[i]) ffs_idx = VW'(i);
		end
	end

	always_comb begin
		sts           = '0;
		sts.edge_ok   = (req_from != '0) && (req_from <= MAXV) &&
		                (req_to != '0) && (req_to <= MAXV);
		sts.root_nz   = |unvis;
		sts.cand_nz   = |cand;
		sts.depth_one = (depth_q == NW'(1));
		sts.emit_last = ((NW'(v_q) + NW'(1)) == n_q);
		sts.out_free  = !rsp_valid_q || rsp_ready;
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vc_q        <= VTX_W'(1);
			row_ok_q    <= '0;
			n_q         <= NW'(1);
			visited_q   <= '0;
			depth_q     <= '0;
			time_q      <= TIME_W'(1);
			top_q       <= '0;
			v_q         <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (cfg_we) vc_q <= cfg_wdata;
			if (cmd.clear_all) begin
				row_ok_q <= '0;
			end else if (cmd.edge_wr) begin
				row_ok_q[from_idx] <= 1'b1;
			end
			if (cmd.run_init) begin
				n_q       <= NW'(n_clamp);
				visited_q <= '0;
				depth_q   <= '0;
				time_q    <= TIME_W'(1);
				v_q       <= '0;
			end
			if (mark) begin
				visited_q <= visited_q | (ONE_BIT << ffs_idx);
				depth_q   <= depth_q + NW'(1);
				top_q     <= ffs_idx;
			end
			if (cmd.pop) depth_q <= depth_q - NW'(1);
			if (mark || cmd.pop) time_q <= time_q + TIME_W'(1);
			if (cmd.top_load) top_q <= stk_rd_q;
			if (cmd.emit_ld) begin
				v_q         <= v_q + VW'(1);
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// memories and payload registers
	always_ff @(posedge clk) begin
		if (cmd.latch_edge) begin
			from_q <= req_from;
			to_q   <= req_to;
		end
		if (cmd.edge_rd || cmd.row_rd) begin
			row_q       <= adj_mem[rd_addr];
			row_ok_rd_q <= row_ok_q[rd_addr];
		end
		if (cmd.edge_wr) adj_mem[from_idx] <= row_eff | (ONE_BIT << to_idx);

		if (mark) begin
			disc_mem[ffs_idx]          <= time_q;
			stk_mem[depth_q[VW-1:0]]   <= ffs_idx;
		end
		if (cmd.pop) begin
			fin_mem[top_q] <= time_q;
			if (depth_q != NW'(1)) stk_rd_q <= stk_mem[VW'(depth_q - NW'(2))];
		end
		if (cmd.emit_rd) begin
			disc_rd_q <= disc_mem[v_q];
			fin_rd_q  <= fin_mem[v_q];
		end
		if (cmd.emit_ld) begin
			rsp_vertex_q <= VTX_W'(v_q) + VTX_W'(1);
			rsp_disc_q   <= disc_rd_q;
			rsp_fin_q    <= fin_rd_q;
			rsp_last_q   <= sts.emit_last;
		end
	end

	assign rsp_valid         = rsp_valid_q;
	assign rsp_vertex        = rsp_vertex_q;
	assign rsp_discover_time = rsp_disc_q;
	assign rsp_finish_time   = rsp_fin_q;
	assign rsp_last          = rsp_last_q;

	`DFS_ASSERT(a_no_overflow, clk, arst_n, !mark || (depth_q < n_q), "push onto a full path stack")
	`DFS_ASSERT(a_no_underflow, clk, arst_n, !cmd.pop || (depth_q != '0), "pop from an empty path stack")
	`DFS_ASSERT(a_time_bound, clk, arst_n, (9'(time_q) <= ((9'(n_q) << 1) + 9'd1)), "time counter beyond two stamps per vertex")

endmodule

/* rtl/dfs_discover_finish_timestamps.sv */
// Top level of the depth-first search timestamp block: controller plus datapath.
// Depends on dfs_pkg, dfs_req_if, dfs_rsp_if, dfs_ctrl and dfs_dp.
//
//  channel | dir | handshake   | beat
//  --------+-----+-------------+-----------------------------------------------
//  req     | in  | valid/ready | cmd, from_vertex, to_vertex
//  rsp     | out | valid/ready | vertex, discover_time, finish_time, last
//  cfg     | in  | cfg_we      | cfg_wdata = vertex_count
//
// Add edge: idle latches it, ST_EDGE_RD reads the row, ST_EDGE_WR writes it back; a
// clear, an invalid edge or an unknown command stays in idle. Run: every search step
// reads one adjacency row through the single memory read port, a pop adds a stack read.
// Results pass ST_EMIT_RD, then ST_EMIT_LD; a held rsp.ready stalls the emit sequence only.
// req.ready is high only between commands; the result register frees that side.
// Reset (arst_n low) clears the row valid bits, so the graph is empty at once.
module dfs_discover_finish_timestamps #(
	parameter int MAX_VERTICES = dfs_pkg::DEF_MAX_VERTICES
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_we,
	input  logic [dfs_pkg::VTX_W-1:0] cfg_wdata,
	dfs_req_if.sink                   req,
	dfs_rsp_if.source                 rsp
);
	import dfs_pkg::*;

	dfs_cmd_t cmd;
	dfs_sts_t sts;

	dfs_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_cmd   (req.cmd),
		.req_ready (req.ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	dfs_dp #(
		.MAX_VERTICES (MAX_VERTICES)
	) u_dp (
		.clk               (clk),
		.arst_n            (arst_n),
		.cfg_we            (cfg_we),
		.cfg_wdata         (cfg_wdata),
		.req_from          (req.from_vertex),
		.req_to            (req.to_vertex),
		.cmd               (cmd),
		.sts               (sts),
		.rsp_ready         (rsp.ready),
		.rsp_valid         (rsp.valid),
		.rsp_vertex        (rsp.vertex),
		.rsp_discover_time (rsp.discover_time),
		.rsp_finish_time   (rsp.finish_time),
		.rsp_last          (rsp.last)
	);

endmodule

/* dv/tb.sv */
// Testbench for dfs_discover_finish_timestamps: loads graphs, runs searches and checks each
// timestamp beat against a predictor of the search. Depends on dfs_pkg, dfs_req_if,
// dfs_rsp_if and the top-level RTL.
`timescale 1ns / 1ps

module tb;
	import dfs_pkg::*;

	localparam int MAXV        = DEF_MAX_VERTICES;
	localparam int RAND_ITEMS  = 70;
	localparam int SETTLE      = 16;
	localparam int TAIL_CYCLES = 64;
	localparam int LIMIT       = 400000;
	localparam logic [CMD_W-1:0] CMD_UNKNOWN = 2'd3;

	typedef struct packed {
		logic [VTX_W-1:0]  vertex;
		logic [TIME_W-1:0] disc;
		logic [TIME_W-1:0] fin;
		logic              last;
	} stamp_t;

	typedef struct packed {
		bit                wr_cfg;
		logic [VTX_W-1:0]  cfg_val;
		logic [CMD_W-1:0]  op;
		logic [VTX_W-1:0]  src;
		logic [VTX_W-1:0]  dst;
		bit                typed;
		logic [TIME_W-1:0] t_disc;
		logic [TIME_W-1:0] t_fin;
	} vec_t;

	logic             clk;
	logic             arst_n;
	logic             cfg_we;
	logic [VTX_W-1:0] cfg_wdata;

	dfs_req_if req_ch();
	dfs_rsp_if rsp_ch();

	dfs_discover_finish_timestamps dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata),
		.req      (req_ch),
		.rsp      (rsp_ch)
	);

	// predictor state
	logic [MAXV-1:0]  adj_rows [MAXV];
	logic [VTX_W-1:0] count_shadow;
	stamp_t           stamps_due [$];
	vec_t             vec_rows [$];

	int  err_cnt;
	int  cycle_cnt;
	bit  calm;
	int  hold_cnt;

	initial clk = 1'b0;
	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt > LIMIT) begin
			$display("tb failed");
			$finish;
		end
	end

	function automatic int unsigned used_vertices(logic [VTX_W-1:0] raw);
		if (raw == 0)
			return 1;
		if (raw > MAXV)
			return MAXV;
		return {{(32-VTX_W){1'b0}}, raw};
	endfunction

	// Iterative DFS: lowest undiscovered neighbor first, each tree starts with an empty stack.
	function automatic void stamp_search();
		logic [MAXV-1:0]   live;
		logic [MAXV-1:0]   seen;
		logic [MAXV-1:0]   cand;
		logic [5:0]        path [MAXV];
		logic [TIME_W-1:0] d_t [MAXV];
		logic [TIME_W-1:0] f_t [MAXV];
		int                n;
		int                depth;
		int                top;
		int                nxt;
		int                tick;
		stamp_t            s;
		n = used_vertices(count_shadow);
		live = (n >= MAXV) ? '1 : ((64'd1 << n) - 64'd1);
		seen = '0;
		tick = 1;
		for (int root = 0; root < n; root++) begin
			if (seen[root])
				continue;
			depth = 0;
			seen[root] = 1'b1;
			d_t[root] = tick[TIME_W-1:0];
			tick++;
			path[depth] = root[5:0];
			depth++;
			while (depth > 0) begin
				top = int'(path[depth-1]);
				cand = adj_rows[top] & ~seen & live;
				if (cand != 0) begin
					nxt = 0;
					while (!cand[nxt])
						nxt++;
					seen[nxt] = 1'b1;
					d_t[nxt] = tick[TIME_W-1:0];
					tick++;
					if (depth < MAXV) begin
						path[depth] = nxt[5:0];
						depth++;
					end
				end else begin
					f_t[top] = tick[TIME_W-1:0];
					tick++;
					depth--;
				end
			end
		end
		for (int v = 0; v < n; v++) begin
			s.vertex = VTX_W'(v + 1);
			s.disc   = d_t[v];
			s.fin    = f_t[v];
			s.last   = (v + 1 == n);
			stamps_due.push_back(s);
		end
	endfunction

	// Updates the graph shadow for an accepted beat; returns 1 unless the block ignores it.
	function automatic bit predict_beat(logic [CMD_W-1:0] op, logic [VTX_W-1:0] src,
			logic [VTX_W-1:0] dst, bit typed);
		if (op == CMD_ADD) begin
			if (src >= 1 && src <= MAXV && dst >= 1 && dst <= MAXV) begin
				adj_rows[src-1][dst-1] = 1'b1;
				return 1;
			end
			return 0;
		end
		if (op == CMD_CLEAR) begin
			for (int i = 0; i < MAXV; i++)
				adj_rows[i] = '0;
			return 1;
		end
		if (op == CMD_RUN) begin
			if (!typed)
				stamp_search();
			return 1;
		end
		return 0;
	endfunction

	task automatic drive_beat(input logic [CMD_W-1:0] op, input logic [VTX_W-1:0] src,
			input logic [VTX_W-1:0] dst, input bit typed, output bit counted);
		int gap;
		@(negedge clk);
		if (!calm && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 5);
			req_ch.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		req_ch.valid       <= 1'b1;
		req_ch.cmd         <= op;
		req_ch.from_vertex <= src;
		req_ch.to_vertex   <= dst;
		do
			@(posedge clk);
		while (!req_ch.ready);
		counted = predict_beat(op, src, dst, typed);
	endtask

	task automatic wait_drained();
		@(negedge clk);
		req_ch.valid <= 1'b0;
		while (stamps_due.size() != 0)
			@(posedge clk);
	endtask

	// Register write only with the block idle; adds and clears leave no beat to wait on.
	task automatic load_count(input logic [VTX_W-1:0] raw);
		wait_drained();
		repeat (SETTLE) @(negedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= raw;
		@(negedge clk);
		cfg_we <= 1'b0;
		count_shadow = raw;
	endtask

	task automatic put_row(input bit wr, input logic [VTX_W-1:0] cv, input logic [CMD_W-1:0] op,
			input logic [VTX_W-1:0] src, input logic [VTX_W-1:0] dst, input bit typed,
			input logic [TIME_W-1:0] td, input logic [TIME_W-1:0] tf);
		vec_t r;
		r.wr_cfg  = wr;
		r.cfg_val = cv;
		r.op      = op;
		r.src     = src;
		r.dst     = dst;
		r.typed   = typed;
		r.t_disc  = td;
		r.t_fin   = tf;
		vec_rows.push_back(r);
	endtask

	// receiver drops ready in random bursts until the traffic turns calm
	always @(negedge clk) begin
		if (hold_cnt != 0) begin
			hold_cnt <= hold_cnt - 1;
		end else if (!calm && $urandom_range(0, 4) == 0) begin
			rsp_ch.ready <= 1'b0;
			hold_cnt <= $urandom_range(0, 4);
		end else begin
			rsp_ch.ready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		stamp_t exp_s;
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			if (stamps_due.size() == 0) begin
				$error("unexpected result beat for vertex %0d", rsp_ch.vertex);
				err_cnt++;
			end else begin
				exp_s = stamps_due.pop_front();
				if (rsp_ch.vertex !== exp_s.vertex) begin
					$error("vertex: expected %0d, got %0d", exp_s.vertex, rsp_ch.vertex);
					err_cnt++;
				end
				if (rsp_ch.discover_time !== exp_s.disc) begin
					$error("discover_time: expected %0d, got %0d", exp_s.disc,
						rsp_ch.discover_time);
					err_cnt++;
				end
				if (rsp_ch.finish_time !== exp_s.fin) begin
					$error("finish_time: expected %0d, got %0d", exp_s.fin,
						rsp_ch.finish_time);
					err_cnt++;
				end
				if (rsp_ch.last !== exp_s.last) begin
					$error("last: expected %0d, got %0d", exp_s.last, rsp_ch.last);
					err_cnt++;
				end
			end
		end
	end

	initial begin
		vec_t             r;
		stamp_t           s;
		bit               counted;
		int               rand_items;
		int               n;
		int               arcs;
		int               pick;
		logic [VTX_W-1:0] raw;
		logic [VTX_W-1:0] src;
		logic [VTX_W-1:0] dst;

		arst_n             = 1'b0;
		cfg_we             = 1'b0;
		cfg_wdata          = '0;
		req_ch.valid       = 1'b0;
		req_ch.cmd         = CMD_ADD;
		req_ch.from_vertex = '0;
		req_ch.to_vertex   = '0;
		rsp_ch.ready       = 1'b0;
		err_cnt            = 0;
		cycle_cnt          = 0;
		calm               = 1'b0;
		hold_cnt           = 0;
		rand_items         = 0;
		count_shadow       = 7'd1;
		for (int i = 0; i < MAXV; i++)
			adj_rows[i] = '0;

		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// single-vertex runs: discover 1, finish 2
		put_row(0, 0,   CMD_RUN,     0,   0,   1, 1, 2);
		put_row(1, 0,   CMD_RUN,     0,   0,   1, 1, 2);
		put_row(0, 0,   CMD_ADD,     1,   1,   0, 0, 0);
		put_row(0, 0,   CMD_RUN,     0,   0,   1, 1, 2);
		// out-of-range edges are dropped
		put_row(0, 0,   CMD_ADD,     0,   5,   0, 0, 0);
		put_row(0, 0,   CMD_ADD,     65,  3,   0, 0, 0);
		put_row(0, 0,   CMD_ADD,     3,   0,   0, 0, 0);
		put_row(0, 0,   CMD_ADD,     127, 127, 0, 0, 0);
		put_row(0, 0,   CMD_ADD,     2,   65,  0, 0, 0);
		put_row(0, 0,   CMD_UNKNOWN, 127, 127, 0, 0, 0);
		put_row(1, 127, CMD_RUN,     0,   0,   0, 0, 0);
		put_row(0, 0,   CMD_ADD,     64,  1,   0, 0, 0);
		put_row(0, 0,   CMD_ADD,     1,   64,  0, 0, 0);
		put_row(0, 0,   CMD_ADD,     1,   2,   0, 0, 0);
		put_row(0, 0,   CMD_ADD,     2,   3,   0, 0, 0);
		put_row(0, 0,   CMD_ADD,     3,   2,   0, 0, 0);
		put_row(0, 0,   CMD_ADD,     3,   1,   0, 0, 0);
		put_row(0, 0,   CMD_RUN,     0,   0,   0, 0, 0);
		// edges to vertex 64 stay stored but are out of view
		put_row(1, 3,   CMD_RUN,     0,   0,   0, 0, 0);
		put_row(0, 0,   CMD_CLEAR,   0,   0,   0, 0, 0);
		put_row(0, 0,   CMD_RUN,     0,   0,   0, 0, 0);
		put_row(1, 1,   CMD_RUN,     0,   0,   1, 1, 2);
		put_row(1, 64,  CMD_ADD,     64,  63,  0, 0, 0);
		put_row(0, 0,   CMD_ADD,     5,   64,  0, 0, 0);
		put_row(0, 0,   CMD_RUN,     0,   0,   0, 0, 0);

		foreach (vec_rows[i]) begin
			r = vec_rows[i];
			if (r.wr_cfg)
				load_count(r.cfg_val);
			if (r.typed) begin
				s.vertex = 1;
				s.disc   = r.t_disc;
				s.fin    = r.t_fin;
				s.last   = 1'b1;
				stamps_due.push_back(s);
			end
			drive_beat(r.op, r.src, r.dst, r.typed, counted);
		end

		// random phases: set the count, build a graph, search it
		while (rand_items < RAND_ITEMS) begin
			pick = $urandom_range(0, 7);
			if (pick == 0)
				raw = VTX_W'(MAXV);
			else if (pick == 1)
				raw = VTX_W'($urandom_range(0, 127));
			else
				raw = VTX_W'($urandom_range(1, 12));
			load_count(raw);
			n = used_vertices(raw);
			if ($urandom_range(0, 1)) begin
				drive_beat(CMD_CLEAR, VTX_W'($urandom_range(0, 127)),
					VTX_W'($urandom_range(0, 127)), 0, counted);
				rand_items += int'(counted);
			end
			arcs = $urandom_range(0, (n < 10) ? 2 * n : 20);
			repeat (arcs) begin
				if ($urandom_range(0, 9) == 0) begin
					drive_beat(CMD_W'($urandom_range(0, 3)), VTX_W'($urandom_range(0, 127)),
						VTX_W'($urandom_range(0, 127)), 0, counted);
				end else begin
					src = VTX_W'($urandom_range(1, n));
					// successor arcs build deep paths
					if ($urandom_range(0, 1))
						dst = VTX_W'($urandom_range(1, n));
					else
						dst = VTX_W'(src % n + 1);
					drive_beat(CMD_ADD, src, dst, 0, counted);
				end
				rand_items += int'(counted);
			end
			drive_beat(CMD_RUN, VTX_W'($urandom_range(0, 127)),
				VTX_W'($urandom_range(0, 127)), 0, counted);
			rand_items += int'(counted);
			if ($urandom_range(0, 3) == 0) begin
				drive_beat(CMD_RUN, 0, 0, 0, counted);
				rand_items += int'(counted);
			end
			if (rand_items >= RAND_ITEMS * 4 / 5)
				calm = 1'b1;
		end

		wait_drained();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (err_cnt == 0 && stamps_due.size() == 0)
			$display("tb passed");
		else
			$display("tb failed");
		$finish;
	end

endmodule
